/* hw/rtl/integral_image_rect_sum_assert.svh */
// Assertion macros shared by the integral image block.
`ifndef INTEGRAL_IMAGE_RECT_SUM_ASSERT_SVH
`define INTEGRAL_IMAGE_RECT_SUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IIRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integral_image_rect_sum assertion failed");

// Next-cycle implication, checked out of reset.
`define IIRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integral_image_rect_sum assertion failed");

`endif

/* hw/rtl/iirs_pkg.sv */
// Shared types and constants for the integral image block.
package iirs_pkg;

    localparam int SUM_W          = 42;
    localparam int OUT_DATA_W     = ((SUM_W + 7) / 8) * 8;
    localparam int DIM_W          = 6;
    localparam int COORD_W        = 5;
    localparam int CMP_W          = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;
    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;
    localparam int DEF_PIXEL_BITS = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SQUARED_MODE = 2'd2
    } cfg_idx_t;

    // Input beat kinds
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Effective configuration seen by the core
    typedef struct packed {
        logic [DIM_W-1:0] img_w;
        logic [DIM_W-1:0] img_h;
        logic             squared;
        logic             restart;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             err;
        logic             done;
    } result_t;

endpackage

/* hw/rtl/iirs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module iirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/iirs_cfg.sv */
// Configuration registers with clamping of the image dimensions.
module iirs_cfg
    import iirs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [DIM_W-1:0] width_reg,  width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             sq_reg,     sq_next;
    logic             hit;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > maxv)
            r = DIM_W'(maxv);
        else
            r = v;
        return r;
    endfunction

    // Register decode
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        sq_next     = sq_reg;
        hit         = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[DIM_W-1:0];
                    hit        = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[DIM_W-1:0];
                    hit         = 1'b1;
                end
                CFG_SQUARED_MODE:
                begin
                    sq_next = cfg_data[0];
                    hit     = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            sq_reg     <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            sq_reg     <= sq_next;
        end
    end

    assign cfg.img_w   = eff_dim(width_reg, MAX_WIDTH);
    assign cfg.img_h   = eff_dim(height_reg, MAX_HEIGHT);
    assign cfg.squared = sq_reg;
    assign cfg.restart = hit;

endmodule

/* hw/rtl/iirs_core.sv */
// Sequencer and datapath: builds the table in RAM and answers rectangle queries.
module iirs_core
    import iirs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [COORD_W-1:0]    rect_x,
    input  logic [COORD_W-1:0]    rect_y,
    input  logic [DIM_W-1:0]      rect_w,
    input  logic [DIM_W-1:0]      rect_h,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [SUM_W-1:0]      ram_wdata,
    output logic                  ram_re,
    output logic [AW-1:0]         ram_raddr,
    input  logic [SUM_W-1:0]      ram_rdata
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LD_MUL, S_LD_ROW, S_LD_SUM,
        S_Q_CHK, S_Q_RD0, S_Q_RD1, S_Q_RD2, S_Q_RD3, S_Q_ACC,
        S_EMIT
    } state_t;

    // Control state
    state_t           state_reg,    state_next;
    logic [CW-1:0]    col_reg,      col_next;
    logic [RW-1:0]    row_reg,      row_next;
    logic [SUM_W-1:0] rowsum_reg,   rowsum_next;
    logic             complete_reg, complete_next;
    logic             ovalid_reg,   ovalid_next;

    // Payload
    logic signed [PIXEL_BITS-1:0] pix_reg, pix_next;
    logic [COORD_W-1:0] qx_reg, qx_next;
    logic [COORD_W-1:0] qy_reg, qy_next;
    logic [DIM_W-1:0]   qw_reg, qw_next;
    logic [DIM_W-1:0]   qh_reg, qh_next;
    logic [SUM_W-1:0]   term_reg, term_next;
    logic [SUM_W-1:0]   acc_reg,  acc_next;
    logic [CW-1:0]      xl_reg, xl_next, xr_reg, xr_next;
    logic [RW-1:0]      yt_reg, yt_next, yb_reg, yb_next;
    logic               left_reg, left_next, top_reg, top_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    logic signed [2*PIXEL_BITS-1:0] prod;
    logic [CW-1:0]      ecol;
    logic [RW-1:0]      erow;
    logic [SUM_W-1:0]   ld_sum;
    logic [CMP_W-1:0]   qx_end, qy_end;
    logic               q_err;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        return AW'(32'(r) * MAX_WIDTH + 32'(c));
    endfunction

    assign prod   = pix_reg * pix_reg;
    assign ecol   = complete_reg ? '0 : col_reg;
    assign erow   = complete_reg ? '0 : row_reg;
    assign ld_sum = rowsum_reg + ((row_reg != '0) ? ram_rdata : '0);
    assign qx_end = CMP_W'(qx_reg) + CMP_W'(qw_reg);
    assign qy_end = CMP_W'(qy_reg) + CMP_W'(qh_reg);
    assign q_err  = !complete_reg || (qw_reg == '0) || (qh_reg == '0)
                  || (qx_end > CMP_W'(cfg.img_w)) || (qy_end > CMP_W'(cfg.img_h));

    // Next-state and datapath
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        rowsum_next   = rowsum_reg;
        complete_next = complete_reg;
        ovalid_next   = ovalid_reg;
        pix_next      = pix_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        qw_next       = qw_reg;
        qh_next       = qh_reg;
        term_next     = term_reg;
        acc_next      = acc_reg;
        xl_next       = xl_reg;
        xr_next       = xr_reg;
        yt_next       = yt_reg;
        yb_next       = yb_reg;
        left_next     = left_reg;
        top_next      = top_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = ld_sum;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        // Output register drains on a taken beat
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next   = pixel;
                    qx_next    = rect_x;
                    qy_next    = rect_y;
                    qw_next    = rect_w;
                    qh_next    = rect_h;
                    state_next = (op == OP_LOAD) ? S_LD_MUL : S_Q_CHK;
                end
            end
            // Load: square or extend the pixel, fetch the entry above
            S_LD_MUL:
            begin
                col_next      = ecol;
                row_next      = erow;
                complete_next = 1'b0;
                term_next     = cfg.squared ? SUM_W'(prod) : SUM_W'(pix_reg);
                ram_re        = 1'b1;
                ram_raddr     = addr_of(ecol, (erow != '0) ? RW'(erow - 1'b1) : '0);
                state_next    = S_LD_ROW;
            end
            S_LD_ROW:
            begin
                rowsum_next = ((col_reg == '0) ? '0 : rowsum_reg) + term_reg;
                state_next  = S_LD_SUM;
            end
            // Load: store the new entry and step the raster position
            S_LD_SUM:
            begin
                ram_we        = 1'b1;
                ram_waddr     = addr_of(col_reg, row_reg);
                res_next.sum  = ld_sum;
                res_next.err  = 1'b0;
                res_next.done = 1'b0;
                if ((CMP_W'(col_reg) + 1'b1) >= CMP_W'(cfg.img_w))
                begin
                    col_next = '0;
                    if ((CMP_W'(row_reg) + 1'b1) >= CMP_W'(cfg.img_h))
                    begin
                        row_next      = '0;
                        complete_next = 1'b1;
                        res_next.done = 1'b1;
                    end
                    else
                    begin
                        row_next = RW'(row_reg + 1'b1);
                    end
                end
                else
                begin
                    col_next = CW'(col_reg + 1'b1);
                end
                state_next = S_EMIT;
            end
            // Query: bounds check and corner coordinates
            S_Q_CHK:
            begin
                xr_next   = CW'(qx_end - 1'b1);
                yb_next   = RW'(qy_end - 1'b1);
                xl_next   = (qx_reg != '0) ? CW'(qx_reg - 1'b1) : '0;
                yt_next   = (qy_reg != '0) ? RW'(qy_reg - 1'b1) : '0;
                left_next = (qx_reg != '0);
                top_next  = (qy_reg != '0);
                if (q_err)
                begin
                    res_next.sum  = '0;
                    res_next.err  = 1'b1;
                    res_next.done = 1'b0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_Q_RD0;
                end
            end
            // Query: four corner reads through the single read port
            S_Q_RD0:
            begin
                ram_re     = 1'b1;
                ram_raddr  = addr_of(xr_reg, yb_reg);
                state_next = S_Q_RD1;
            end
            S_Q_RD1:
            begin
                acc_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = addr_of(xl_reg, yb_reg);
                state_next = S_Q_RD2;
            end
            S_Q_RD2:
            begin
                acc_next   = acc_reg - (left_reg ? ram_rdata : '0);
                ram_re     = 1'b1;
                ram_raddr  = addr_of(xr_reg, yt_reg);
                state_next = S_Q_RD3;
            end
            S_Q_RD3:
            begin
                acc_next   = acc_reg - (top_reg ? ram_rdata : '0);
                ram_re     = 1'b1;
                ram_raddr  = addr_of(xl_reg, yt_reg);
                state_next = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                res_next.sum  = acc_reg + ((left_reg && top_reg) ? ram_rdata : '0);
                res_next.err  = 1'b0;
                res_next.done = 1'b0;
                state_next    = S_EMIT;
            end
            // Hand the result to the output register once it is free
            S_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Register write restarts loading
        if (cfg.restart)
        begin
            col_next      = '0;
            row_next      = '0;
            rowsum_next   = '0;
            complete_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            rowsum_reg   <= '0;
            complete_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            rowsum_reg   <= rowsum_next;
            complete_reg <= complete_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        qw_reg   <= qw_next;
        qh_reg   <= qh_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        xl_reg   <= xl_next;
        xr_reg   <= xr_next;
        yt_reg   <= yt_next;
        yb_reg   <= yb_next;
        left_reg <= left_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_res   = out_reg;

endmodule

/* hw/rtl/integral_image_rect_sum.sv */
// Top level of the integral image (summed-area table) block.
// Usage:
//   Input stream s_*: s_tuser selects the beat kind (0 load a pixel, 1 query).
//   Loads arrive in raster order; each returns the new table entry, with m_tlast
//   high on the entry that completes the image. A query returns the four-corner
//   rectangle sum, or m_tuser high and a zero sum when the rectangle is empty,
//   leaves the image, or the image is not yet complete.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 width,
//   1 height, 2 squared mode); such a write restarts loading at the first pixel.
// Flow:
//   One beat is worked at a time; s_tready stays low from a beat's accept until
//   its result has passed to the output register. The rate is set by the single
//   read port of the table RAM: a query reads its four corners in sequence.
//   A finished result waits in the output register while the next beat is
//   accepted; if the receiver stalls, the sequencer holds its next result
//   and stops accepting input until the output register drains.
// Reset: clears the sequencer, raster position and image-complete flag; width and
//   height return to 24, squared mode to 0. The table RAM is not cleared.
module integral_image_rect_sum
    import iirs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int IN_FIELDS_W = PIXEL_BITS + 2*COORD_W + 2*DIM_W,
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_value, rect_x, rect_y, rect_width, rect_height, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sum_value, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // error_flag
    output logic                  m_tuser,
    // image_done
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "integral_image_rect_sum_assert.svh"

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int X_LO  = PIXEL_BITS;
    localparam int Y_LO  = X_LO + COORD_W;
    localparam int W_LO  = Y_LO + COORD_W;
    localparam int H_LO  = W_LO + DIM_W;

    cfg_t             cfg;
    result_t          res;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SUM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [SUM_W-1:0] ram_rdata;

    iirs_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iirs_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .pixel     (s_tdata[PIXEL_BITS-1:0]),
        .rect_x    (s_tdata[X_LO +: COORD_W]),
        .rect_y    (s_tdata[Y_LO +: COORD_W]),
        .rect_w    (s_tdata[W_LO +: DIM_W]),
        .rect_h    (s_tdata[H_LO +: DIM_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Table store, one entry per pixel at row*MAX_WIDTH+column
    iirs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output beat packing
    assign m_tdata = OUT_DATA_W'(res.sum);
    assign m_tuser = res.err;
    assign m_tlast = res.done;

    // Checks
    `IIRS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `IIRS_ASSERT_IMP(a_done_never_err, m_tvalid && m_tlast, !m_tuser)
    `IIRS_ASSERT_IMP(a_err_sum_zero, m_tvalid && m_tuser, m_tdata[SUM_W-1:0] == '0)

endmodule

/* bench/integral_image_rect_sum_test.sv */
// Self-checking testbench for the integral image rectangle-sum block.
module integral_image_rect_sum_test;
    import iirs_pkg::*;

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int IN_W  = ((DEF_PIXEL_BITS + 2*COORD_W + 2*DIM_W + 7) / 8) * 8;

    // DUT ports, all inputs known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block: summed-area table, raster position and registers
    logic [SUM_W-1:0]      table_entries [0:MAX_W*MAX_H-1];
    logic [SUM_W-1:0]      row_acc;
    int unsigned           raster_col;
    int unsigned           raster_row;
    bit                    image_ready;
    logic [DIM_W-1:0]      reg_width;
    logic [DIM_W-1:0]      reg_height;
    logic                  reg_squared;

    result_t               pending_results [$];
    bit                    beat_held;
    bit                    no_idle;
    int unsigned           error_count;
    int unsigned           beats_sent;
    int unsigned           loads_sent;
    int unsigned           queries_sent;
    int unsigned           results_checked;

    integral_image_rect_sum i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Dimension register as the block uses it: 0 acts as 1, clipped at max
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void restart_raster();
        row_acc     = '0;
        raster_col  = 0;
        raster_row  = 0;
        image_ready = 1'b0;
    endfunction

    // Expected result of one beat; updates the shadow table on loads
    function automatic result_t compute_beat_result(op_t op, logic [15:0] pix,
                                                    logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y,
                                                    logic [DIM_W-1:0] rw,
                                                    logic [DIM_W-1:0] rh);
        int unsigned             w;
        int unsigned             h;
        int unsigned             xr;
        int unsigned             yb;
        logic signed [SUM_W-1:0] sample;
        logic [SUM_W-1:0]        term;
        result_t                 r;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        r = '0;
        if (op == OP_LOAD)
        begin
            sample = $signed(pix);
            term = reg_squared ? sample * sample : sample;
            if (image_ready)
                restart_raster();
            row_acc = (raster_col == 0) ? term : row_acc + term;
            r.sum = row_acc;
            if (raster_row > 0)
                r.sum = r.sum + table_entries[(raster_row - 1) * MAX_W + raster_col];
            table_entries[raster_row * MAX_W + raster_col] = r.sum;
            raster_col++;
            if (raster_col >= w)
            begin
                raster_col = 0;
                raster_row++;
                if (raster_row >= h)
                begin
                    raster_row  = 0;
                    image_ready = 1'b1;
                    r.done      = 1'b1;
                end
            end
        end
        else if (!image_ready || rw == 0 || rh == 0 || x + rw > w || y + rh > h)
        begin
            r.err = 1'b1;
        end
        else
        begin
            // four-corner rule, corners off the left or top border dropped
            xr = x + rw - 1;
            yb = y + rh - 1;
            r.sum = table_entries[yb * MAX_W + xr];
            if (x > 0)
                r.sum = r.sum - table_entries[yb * MAX_W + x - 1];
            if (y > 0)
                r.sum = r.sum - table_entries[(y - 1) * MAX_W + xr];
            if (x > 0 && y > 0)
                r.sum = r.sum + table_entries[(y - 1) * MAX_W + x - 1];
        end
        return r;
    endfunction

    // Idle length for either side: mostly none or short, a few long
    function automatic int unsigned pick_idle();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        $display("MISMATCH result %0d %s: expected %0h, got %0h",
                 results_checked, what, want, got);
    endtask

    // One input beat; valid stays up when the next beat follows with no gap
    task automatic send_beat(input op_t op, input logic [15:0] pix,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [DIM_W-1:0] rw, input logic [DIM_W-1:0] rh);
        int unsigned     gap;
        logic [IN_W-1:0] word;
        gap = pick_idle();
        if (gap > 0)
        begin
            if (beat_held)
                s_tvalid <= 1'b0;
            beat_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
        word = '0;
        word[DEF_PIXEL_BITS + 2*COORD_W + 2*DIM_W - 1:0] = {rh, rw, y, x, pix};
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        beat_held = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(),
                               compute_beat_result(op, pix, x, y, rw, rh));
        beats_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        else
            queries_sent++;
    endtask

    task automatic send_load(input logic [15:0] pix);
        send_beat(OP_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom),
                  DIM_W'($urandom), DIM_W'($urandom));
    endtask

    task automatic send_query(input int unsigned x, input int unsigned y,
                              input int unsigned rw, input int unsigned rh);
        send_beat(OP_QUERY, 16'($urandom), COORD_W'(x), COORD_W'(y), DIM_W'(rw), DIM_W'(rh));
    endtask

    // Rectangle that fits the current geometry
    task automatic send_inside_query();
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        x = $urandom_range(0, w - 1);
        y = $urandom_range(0, h - 1);
        send_query(x, y, $urandom_range(1, w - x), $urandom_range(1, h - y));
    endtask

    task automatic send_any_query();
        send_query($urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        if (beat_held)
        begin
            s_tvalid <= 1'b0;
            beat_held = 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle; any write restarts the raster
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width = val;
            CFG_IMAGE_HEIGHT: reg_height = val;
            CFG_SQUARED_MODE: reg_squared = val[0];
            default: ;
        endcase
        restart_raster();
    endtask

    // Reset geometry (24x24, plain sums), query before the image exists
    task automatic test_default_geometry();
        send_query(0, 0, 1, 1);
        repeat (24 * 24) send_load(rand_pixel());
        wait_drained();
        send_query(0, 0, 24, 24);
        send_query(23, 23, 1, 1);
        send_query(0, 0, 25, 1);
        repeat (18) send_inside_query();
        repeat (4) send_any_query();
    endtask

    // 1x1 and 2x2 images, border corners, rejected queries, restarts
    task automatic test_edge_cases();
        write_reg(CFG_IMAGE_WIDTH, 6'd0);
        write_reg(CFG_IMAGE_HEIGHT, 6'd0);
        send_query(0, 0, 1, 1);
        send_load(16'h7FFF);
        send_query(0, 0, 1, 1);
        send_query(0, 0, 0, 1);
        send_query(0, 0, 1, 0);
        send_query(1, 0, 1, 1);
        send_query(0, 1, 1, 1);
        // load after completion starts a new image
        send_load(16'h8000);
        send_query(0, 0, 1, 1);
        write_reg(CFG_IMAGE_WIDTH, 6'd2);
        write_reg(CFG_IMAGE_HEIGHT, 6'd2);
        write_reg(CFG_SQUARED_MODE, 6'd1);
        send_load(16'h8000);
        send_load(16'h7FFF);
        send_load(16'hFFFF);
        send_load(16'h0000);
        send_query(1, 1, 1, 1);
        send_query(0, 0, 2, 2);
        send_query(1, 0, 1, 2);
        send_query(0, 1, 2, 1);
        // half-loaded image rejects queries; a write restarts it
        send_load(16'h0005);
        send_query(0, 0, 1, 1);
        write_reg(CFG_SQUARED_MODE, 6'd0);
        repeat (4) send_load(rand_pixel());
        send_query(0, 0, 2, 2);
        // oversize registers clip to the maximum
        write_reg(CFG_IMAGE_WIDTH, 6'd63);
        write_reg(CFG_IMAGE_HEIGHT, 6'd33);
        send_query(31, 31, 1, 1);
    endtask

    // Largest image in squared mode, driven hard toward the top of the sum range
    task automatic test_full_squared();
        int unsigned i;
        write_reg(CFG_IMAGE_WIDTH, 6'd32);
        write_reg(CFG_IMAGE_HEIGHT, 6'd32);
        write_reg(CFG_SQUARED_MODE, 6'd1);
        for (i = 0; i < MAX_W * MAX_H; i++)
        begin
            no_idle = (i < 300);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_load(16'h8000);
                6, 7: send_load(16'h7FFF);
                default: send_load(rand_pixel());
            endcase
        end
        no_idle = 1'b0;
        send_query(0, 0, 32, 32);
        send_query(31, 31, 1, 1);
        send_query(31, 0, 1, 32);
        send_query(0, 31, 32, 1);
        repeat (20) send_inside_query();
        repeat (6) send_any_query();
    endtask

    function automatic logic [DIM_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return DIM_W'($urandom_range(33, 63));
            2, 3: return DIM_W'($urandom_range(9, 32));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_height();
        case ($urandom_range(0, 19))
            0: return '0;
            1, 2: return DIM_W'($urandom_range(7, 12));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Mostly whole small images followed by queries; some partial loads and noise
    task automatic test_random_images();
        int unsigned start;
        int unsigned w;
        int unsigned h;
        int unsigned left;
        int unsigned n;
        bit          first;
        start = beats_sent;
        first = 1'b1;
        while (beats_sent - start < 80)
        begin
            if (first || $urandom_range(0, 2) != 0)
            begin
                if (first || $urandom_range(0, 3) != 0)
                    write_reg(CFG_IMAGE_WIDTH, pick_width());
                if (first || $urandom_range(0, 3) != 0)
                    write_reg(CFG_IMAGE_HEIGHT, pick_height());
                if (first || $urandom_range(0, 3) == 0)
                    write_reg(CFG_SQUARED_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            end
            first = 1'b0;
            w = clamp_dim(reg_width, MAX_W);
            h = clamp_dim(reg_height, MAX_H);
            left = image_ready ? w * h : w * h - (raster_row * w + raster_col);
            no_idle = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                7, 8:
                begin
                    n = $urandom_range(1, left);
                    repeat (n) send_load(rand_pixel());
                    repeat (2) send_inside_query();
                end
                9:
                begin
                    repeat (8)
                    begin
                        if ($urandom_range(0, 1))
                            send_load(rand_pixel());
                        else
                            send_any_query();
                    end
                end
                default:
                begin
                    repeat (left) send_load(rand_pixel());
                    n = $urandom_range(2, 10);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 4) != 0)
                            send_inside_query();
                        else
                            send_any_query();
                    end
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, every accepted beat checked in order
    initial
    begin : result_checker
        int unsigned stall_left;
        result_t     want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected beat", '0, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.sum)
                        report_mismatch("sum_value", want.sum, m_tdata[SUM_W-1:0]);
                    if (m_tuser !== want.err)
                        report_mismatch("error_flag", want.err, m_tuser);
                    if (m_tlast !== want.done)
                        report_mismatch("image_done", want.done, m_tlast);
                end
                results_checked++;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_idle();
            end
        end
    end

    // Run limit
    initial
    begin
        #12_000_000;
        $display("integral_image_rect_sum_test: done, errors");
        $finish;
    end

    // Test sequence
    initial
    begin
        reg_width   = DIM_RESET;
        reg_height  = DIM_RESET;
        reg_squared = 1'b0;
        restart_raster();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_geometry();
        test_edge_cases();
        test_full_squared();
        test_random_images();

        wait_drained();
        repeat (12) @(posedge clk);
        $display("summary: %0d pixel loads, %0d rectangle queries, %0d results checked",
                 loads_sent, queries_sent, results_checked);
        $display("summary: reset 24x24 image, 1x1/2x2 borders, full 32x32 squared, %s",
                 "random small images with restarts and rejected queries");
        if (error_count == 0)
            $display("integral_image_rect_sum_test: done, clean");
        else
            $display("integral_image_rect_sum_test: done, errors");
        $finish;
    end

endmodule
